// ----- rtl/ase_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package ase_pkg;

    // Sizing
    localparam int DMEM_BYTES_DEF = 4096;
    localparam int NUM_REGS       = 16;
    localparam int REG_AW         = 4;
    localparam int RD_PORTS       = 3;
    localparam int OUT_DEPTH      = 4;
    localparam int OQ_PTR_W       = $clog2(OUT_DEPTH);
    localparam int OQ_CNT_W       = $clog2(OUT_DEPTH + 1);

    // Register-file read port roles
    localparam int RP_RN = 0;
    localparam int RP_RM = 1;
    localparam int RP_RX = 2;

    localparam logic [REG_AW-1:0] REG_R0 = 4'd0;
    localparam logic [REG_AW-1:0] REG_LR = 4'd14;
    localparam logic [REG_AW-1:0] REG_PC = 4'd15;

    // Request operations
    localparam logic [1:0] OP_EXEC = 2'd0;
    localparam logic [1:0] OP_WREG = 2'd1;
    localparam logic [1:0] OP_WMEM = 2'd2;

    // Instruction classes
    localparam logic [2:0] CLS_BX      = 3'd0;
    localparam logic [2:0] CLS_MUL     = 3'd1;
    localparam logic [2:0] CLS_DP      = 3'd2;
    localparam logic [2:0] CLS_BRANCH  = 3'd3;
    localparam logic [2:0] CLS_LS      = 3'd4;
    localparam logic [2:0] CLS_UNKNOWN = 3'd5;
    localparam logic [2:0] CLS_NONE    = 3'd6;

    // Encoding fields
    localparam logic [23:0] BX_PATTERN = 24'h12FFF1;
    localparam logic [3:0]  MUL_TAG    = 4'b1001;
    localparam logic [2:0]  BR_TAG     = 3'b101;
    localparam logic [1:0]  DP_TAG     = 2'b00;
    localparam logic [1:0]  LS_TAG     = 2'b01;

    // Data-processing opcodes
    localparam logic [3:0] OPC_SUB = 4'b0010;
    localparam logic [3:0] OPC_ADD = 4'b0100;
    localparam logic [3:0] OPC_CMP = 4'b1010;
    localparam logic [3:0] OPC_MOV = 4'b1101;

    // Branch conditions
    localparam logic [3:0] COND_EQ = 4'h0;
    localparam logic [3:0] COND_NE = 4'h1;
    localparam logic [3:0] COND_GE = 4'hA;
    localparam logic [3:0] COND_LT = 4'hB;
    localparam logic [3:0] COND_GT = 4'hC;
    localparam logic [3:0] COND_LE = 4'hD;
    localparam logic [3:0] COND_AL = 4'hE;

    typedef struct packed {
        logic              en;
        logic [REG_AW-1:0] addr;
        logic [31:0]       data;
    } rf_wr_t;

    typedef struct packed {
        logic        en;
        logic        wr;
        logic        byte_op;
        logic [31:0] addr;
        logic [31:0] wdata;
    } dm_cmd_t;

    typedef struct packed {
        logic [31:0] next_pc;
        logic [31:0] r0_value;
        logic [3:0]  flags_nzcv;
        logic [2:0]  inst_class;
        logic        branch_taken;
        logic        halted;
        logic [31:0] dp_count;
        logic [31:0] branch_total;
        logic [31:0] memory_total;
        logic [31:0] taken_total;
    } rsp_t;

endpackage

`default_nettype wire

// ----- rtl/ase_if.sv -----
`timescale 1ns / 1ps
`default_nettype none

interface ase_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  operation;
    logic [31:0] instr_word;
    logic [3:0]  reg_index;
    logic [11:0] mem_addr;
    logic [31:0] write_value;

    modport source (
        output valid, operation, instr_word, reg_index, mem_addr, write_value,
        input  ready
    );
    modport sink (
        input  valid, operation, instr_word, reg_index, mem_addr, write_value,
        output ready
    );
endinterface

interface ase_rsp_if;
    logic        valid;
    logic        ready;
    logic [31:0] next_pc;
    logic [31:0] r0_value;
    logic [3:0]  flags_nzcv;
    logic [2:0]  inst_class;
    logic        branch_taken;
    logic        halted;
    logic [31:0] dp_count;
    logic [31:0] branch_total;
    logic [31:0] memory_total;
    logic [31:0] taken_total;

    modport source (
        output valid, next_pc, r0_value, flags_nzcv, inst_class, branch_taken, halted,
               dp_count, branch_total, memory_total, taken_total,
        input  ready
    );
    modport sink (
        input  valid, next_pc, r0_value, flags_nzcv, inst_class, branch_taken, halted,
               dp_count, branch_total, memory_total, taken_total,
        output ready
    );
endinterface

`default_nettype wire

// ----- rtl/arm_subset_execute_unit.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Executes a small ARM v4 subset (BX, MUL, MOV/ADD/SUB/CMP, B/BL, LDR/STR word
// and byte) one instruction word per request, and also takes requests that
// preload a register or a little-endian memory word. Every request returns one
// response with the program counter after the request (the address of the next
// fetch), r0, the NZCV flags, the instruction class, the taken flag, a halt flag
// that is set when the PC is zero, and four wrapping counters. The register
// file lives in three synchronous RAM copies with a registered read (one per
// read port) and the data memory in four byte-lane banks; the PC, r0, the
// flags and the counters are flip-flops. A request executes in the cycle after
// it is accepted, so register reads, arithmetic and stores run at one request
// per clock while ready is high, with the write of the previous request
// forwarded to the next one's operands. A load's data comes back through the
// banks' registered read and is written to the register file in the write-back
// stage, and no request is accepted while the load waits for it. Data memory
// addresses wrap at DMEM_BYTES, which must be a power of two. After reset the
// block clears the data memory, one row of four bytes per cycle until every
// row is zero, and holds ready low until that is done.
// Up to four responses are queued, so the block keeps accepting requests while
// the response side stalls until that queue is full.
module arm_subset_execute_unit import ase_pkg::*; #(
    parameter int DMEM_BYTES = DMEM_BYTES_DEF
) (
    input  wire logic clk,
    input  wire logic rst_n,
    ase_req_if.sink   req,
    ase_rsp_if.source rsp
);

    // Accept side
    logic                             accept;
    logic                             acc_mul;
    logic                             acc_load;
    logic [RD_PORTS-1:0][REG_AW-1:0]  acc_raddr;

    // Execute stage registers
    logic                             e_valid_reg;
    logic                             e_load_reg;
    logic [1:0]                       e_op_reg;
    logic [31:0]                      e_iw_reg;
    logic [3:0]                       e_ri_reg;
    logic [11:0]                      e_ma_reg;
    logic [31:0]                      e_wv_reg;
    logic [RD_PORTS-1:0][REG_AW-1:0]  e_ra_reg;

    // Load write-back stage registers
    logic                             w_valid_reg;
    logic [REG_AW-1:0]                w_rd_reg;

    // Architectural state kept in flip-flops
    logic [31:0] pc_reg;
    logic [31:0] pc_next;
    logic [31:0] r0_reg;
    logic [31:0] r0_next;
    logic [3:0]  flags_reg;
    logic [3:0]  flags_next;
    logic [31:0] cnt_dp_reg;
    logic [31:0] cnt_dp_next;
    logic [31:0] cnt_br_reg;
    logic [31:0] cnt_br_next;
    logic [31:0] cnt_mem_reg;
    logic [31:0] cnt_mem_next;
    logic [31:0] cnt_tk_reg;
    logic [31:0] cnt_tk_next;

    // Execute datapath
    logic [RD_PORTS-1:0][31:0] rf_rdata;
    logic [RD_PORTS-1:0][31:0] opv;
    logic        d_bx;
    logic        d_mul;
    logic        d_dp;
    logic        d_br;
    logic        d_ls;
    logic [31:0] pc_plus4;
    logic [31:0] dp_op2;
    logic [3:0]  dp_opc;
    logic        dp_sub;
    logic [32:0] alu_sum;
    logic [31:0] alu_res;
    logic [31:0] product;
    logic [31:0] ls_off;
    logic [31:0] ls_addr;
    logic [31:0] br_target;
    logic        cond_ok;
    logic        f_n;
    logic        f_z;
    logic        f_v;
    logic        dp_wen;
    logic [31:0] dp_wval;

    rf_wr_t      e_wr;
    logic [31:0] e_pc_next;
    logic [3:0]  e_flags_next;
    logic [2:0]  e_cls;
    logic        e_taken;
    logic        inc_dp;
    logic        inc_br;
    logic        inc_mem;
    logic        inc_tk;
    dm_cmd_t     e_dm;

    // Shared write port and memory command
    rf_wr_t      rf_wr;
    dm_cmd_t     dm_cmd;
    logic [31:0] dm_rdata;
    logic        dm_busy;
    logic [31:0] w_pc_next;

    // Response queue
    logic                push;
    rsp_t                push_data;
    logic [OQ_CNT_W-1:0] oq_count;
    logic [OQ_CNT_W-1:0] occupancy;

    // ------------------------------------------------------------------
    // Accept: pick register read addresses from the incoming word. Port RN
    // reads the base or first operand, RM the second operand, offset or BX
    // target, and RX either the MUL multiplier or the store data register.
    // ------------------------------------------------------------------
    assign acc_mul  = (req.instr_word[27:4] != BX_PATTERN) &&
                      (req.instr_word[27:22] == 6'd0) &&
                      (req.instr_word[7:4] == MUL_TAG);
    assign acc_load = (req.operation == OP_EXEC) &&
                      (req.instr_word[27:26] == LS_TAG) && req.instr_word[20];

    assign acc_raddr[RP_RN] = req.instr_word[19:16];
    assign acc_raddr[RP_RM] = req.instr_word[3:0];
    assign acc_raddr[RP_RX] = acc_mul ? req.instr_word[11:8] : req.instr_word[15:12];

    // Room is reserved in the response queue for every request in flight, and
    // nothing is taken while a load waits for its data or memory is clearing.
    assign occupancy = oq_count + OQ_CNT_W'(e_valid_reg) + OQ_CNT_W'(w_valid_reg);
    assign req.ready = !dm_busy && !(e_valid_reg && e_load_reg) &&
                       (occupancy < OQ_CNT_W'(OUT_DEPTH));
    assign accept    = req.valid && req.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            e_valid_reg <= 1'b0;
            e_load_reg  <= 1'b0;
            w_valid_reg <= 1'b0;
        end
        else
        begin
            e_valid_reg <= accept;
            e_load_reg  <= accept && acc_load;
            w_valid_reg <= e_valid_reg && e_load_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            e_op_reg <= req.operation;
            e_iw_reg <= req.instr_word;
            e_ri_reg <= req.reg_index;
            e_ma_reg <= req.mem_addr;
            e_wv_reg <= req.write_value;
            e_ra_reg <= acc_raddr;
        end
        if (e_valid_reg && e_load_reg)
        begin
            w_rd_reg <= e_iw_reg[15:12];
        end
    end

    // ------------------------------------------------------------------
    // Execute
    // ------------------------------------------------------------------
    ase_regfile u_regfile (
        .clk   (clk),
        .rst_n (rst_n),
        .raddr (acc_raddr),
        .wr    (rf_wr),
        .rdata (rf_rdata)
    );

    // Register 15 always reads as the current PC.
    for (genvar p = 0; p < RD_PORTS; p++)
    begin : g_opv
        assign opv[p] = (e_ra_reg[p] == REG_PC) ? pc_reg : rf_rdata[p];
    end

    assign d_bx  = (e_iw_reg[27:4] == BX_PATTERN);
    assign d_mul = !d_bx && (e_iw_reg[27:22] == 6'd0) && (e_iw_reg[7:4] == MUL_TAG);
    assign d_dp  = !d_bx && !d_mul && (e_iw_reg[27:26] == DP_TAG);
    assign d_br  = (e_iw_reg[27:25] == BR_TAG);
    assign d_ls  = (e_iw_reg[27:26] == LS_TAG);

    assign pc_plus4 = pc_reg + 32'd4;

    // One adder serves ADD, SUB and CMP; the carry out is the ARM carry.
    assign dp_op2  = e_iw_reg[25] ? {24'd0, e_iw_reg[7:0]} : opv[RP_RM];
    assign dp_opc  = e_iw_reg[24:21];
    assign dp_sub  = (dp_opc != OPC_ADD);
    assign alu_sum = {1'b0, opv[RP_RN]} + {1'b0, (dp_sub ? ~dp_op2 : dp_op2)} +
                     33'(dp_sub);
    assign alu_res = alu_sum[31:0];

    assign product = opv[RP_RM] * opv[RP_RX];

    assign ls_off  = e_iw_reg[25] ? opv[RP_RM] : {20'd0, e_iw_reg[11:0]};
    assign ls_addr = e_iw_reg[23] ? (opv[RP_RN] + ls_off) : (opv[RP_RN] - ls_off);

    assign br_target = pc_reg + {{6{e_iw_reg[23]}}, e_iw_reg[23:0], 2'b00} + 32'd8;

    assign f_n = flags_reg[3];
    assign f_z = flags_reg[2];
    assign f_v = flags_reg[0];

    always_comb
    begin
        unique case (e_iw_reg[31:28])
            COND_EQ: cond_ok = f_z;
            COND_NE: cond_ok = !f_z;
            COND_LT: cond_ok = (f_n != f_v);
            COND_GT: cond_ok = (f_n == f_v) && !f_z;
            COND_GE: cond_ok = (f_n == f_v);
            COND_LE: cond_ok = (f_n != f_v) || f_z;
            COND_AL: cond_ok = 1'b1;
            default: cond_ok = 1'b0;
        endcase
    end

    always_comb
    begin
        unique case (dp_opc) inside
            OPC_MOV:
            begin
                dp_wen  = 1'b1;
                dp_wval = dp_op2;
            end
            OPC_ADD, OPC_SUB:
            begin
                dp_wen  = 1'b1;
                dp_wval = alu_res;
            end
            default:
            begin
                dp_wen  = 1'b0;
                dp_wval = alu_res;
            end
        endcase
    end

    always_comb
    begin
        e_wr         = '0;
        e_pc_next    = pc_reg;
        e_flags_next = flags_reg;
        e_cls        = CLS_NONE;
        e_taken      = 1'b0;
        inc_dp       = 1'b0;
        inc_br       = 1'b0;
        inc_mem      = 1'b0;
        inc_tk       = 1'b0;
        e_dm         = '0;

        unique case (e_op_reg)
            OP_EXEC:
            begin
                if (d_bx)
                begin
                    e_cls     = CLS_BX;
                    inc_br    = 1'b1;
                    e_pc_next = opv[RP_RM];
                end
                else if (d_mul)
                begin
                    e_cls  = CLS_MUL;
                    inc_dp = 1'b1;
                    if (e_iw_reg[19:16] == REG_PC)
                    begin
                        e_pc_next = product;
                    end
                    else
                    begin
                        e_wr      = '{en: 1'b1, addr: e_iw_reg[19:16], data: product};
                        e_pc_next = pc_plus4;
                    end
                end
                else if (d_dp)
                begin
                    e_cls  = CLS_DP;
                    inc_dp = 1'b1;
                    if (dp_opc == OPC_CMP)
                    begin
                        e_flags_next = {alu_res[31], (alu_res == 32'd0), alu_sum[32],
                                        ((opv[RP_RN][31] ^ dp_op2[31]) &
                                         (opv[RP_RN][31] ^ alu_res[31]))};
                    end
                    // A write to the PC replaces it; with Rd the PC and no write, the PC holds; otherwise it steps on.
                    if (e_iw_reg[15:12] == REG_PC)
                    begin
                        if (dp_wen)
                        begin
                            e_pc_next = dp_wval;
                        end
                    end
                    else
                    begin
                        e_wr      = '{en: dp_wen, addr: e_iw_reg[15:12], data: dp_wval};
                        e_pc_next = pc_plus4;
                    end
                end
                else if (d_br)
                begin
                    e_cls  = CLS_BRANCH;
                    inc_br = 1'b1;
                    if (cond_ok)
                    begin
                        e_taken   = 1'b1;
                        inc_tk    = 1'b1;
                        e_pc_next = br_target;
                        if (e_iw_reg[24])
                        begin
                            e_wr = '{en: 1'b1, addr: REG_LR, data: pc_plus4};
                        end
                    end
                    else
                    begin
                        e_pc_next = pc_plus4;
                    end
                end
                else if (d_ls)
                begin
                    e_cls   = CLS_LS;
                    inc_mem = 1'b1;
                    e_dm    = '{en: 1'b1, wr: !e_iw_reg[20], byte_op: e_iw_reg[22],
                                addr: ls_addr, wdata: opv[RP_RX]};
                    // Loads settle the PC when their data returns.
                    if (!e_iw_reg[20])
                    begin
                        e_pc_next = pc_plus4;
                    end
                end
                else
                begin
                    e_cls = CLS_UNKNOWN;
                end
            end
            OP_WREG:
            begin
                if (e_ri_reg == REG_PC)
                begin
                    e_pc_next = e_wv_reg;
                end
                else
                begin
                    e_wr = '{en: 1'b1, addr: e_ri_reg, data: e_wv_reg};
                end
            end
            OP_WMEM:
            begin
                e_dm = '{en: 1'b1, wr: 1'b1, byte_op: 1'b0,
                         addr: {20'd0, e_ma_reg}, wdata: e_wv_reg};
            end
            default:
            begin
                e_cls = CLS_NONE;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Data memory and load write-back
    // ------------------------------------------------------------------
    always_comb
    begin
        dm_cmd    = e_dm;
        dm_cmd.en = e_valid_reg && e_dm.en;
        dm_cmd.wr = e_valid_reg && e_dm.en && e_dm.wr;
    end

    ase_dmem #(
        .DMEM_BYTES (DMEM_BYTES)
    ) u_dmem (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (dm_cmd),
        .rdata (dm_rdata),
        .busy  (dm_busy)
    );

    // A load into the PC still steps it by four afterwards.
    assign w_pc_next = (w_rd_reg == REG_PC) ? (dm_rdata + 32'd4) : pc_plus4;

    // The execute stage and the load write-back never fall in the same cycle,
    // so one register-file write port is enough.
    always_comb
    begin
        if (w_valid_reg)
        begin
            rf_wr = '{en: (w_rd_reg != REG_PC), addr: w_rd_reg, data: dm_rdata};
        end
        else
        begin
            rf_wr    = e_wr;
            rf_wr.en = e_valid_reg && e_wr.en;
        end
    end

    // ------------------------------------------------------------------
    // State update
    // ------------------------------------------------------------------
    always_comb
    begin
        if (w_valid_reg)
        begin
            pc_next = w_pc_next;
        end
        else if (e_valid_reg)
        begin
            pc_next = e_pc_next;
        end
        else
        begin
            pc_next = pc_reg;
        end

        r0_next      = (rf_wr.en && (rf_wr.addr == REG_R0)) ? rf_wr.data : r0_reg;
        flags_next   = e_valid_reg ? e_flags_next : flags_reg;
        cnt_dp_next  = cnt_dp_reg  + 32'(e_valid_reg && inc_dp);
        cnt_br_next  = cnt_br_reg  + 32'(e_valid_reg && inc_br);
        cnt_mem_next = cnt_mem_reg + 32'(e_valid_reg && inc_mem);
        cnt_tk_next  = cnt_tk_reg  + 32'(e_valid_reg && inc_tk);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg      <= '0;
            r0_reg      <= '0;
            flags_reg   <= '0;
            cnt_dp_reg  <= '0;
            cnt_br_reg  <= '0;
            cnt_mem_reg <= '0;
            cnt_tk_reg  <= '0;
        end
        else
        begin
            pc_reg      <= pc_next;
            r0_reg      <= r0_next;
            flags_reg   <= flags_next;
            cnt_dp_reg  <= cnt_dp_next;
            cnt_br_reg  <= cnt_br_next;
            cnt_mem_reg <= cnt_mem_next;
            cnt_tk_reg  <= cnt_tk_next;
        end
    end

    // ------------------------------------------------------------------
    // Responses: loads report from write-back, everything else from execute.
    // ------------------------------------------------------------------
    assign push = (e_valid_reg && !e_load_reg) || w_valid_reg;

    always_comb
    begin
        push_data.next_pc      = pc_next;
        push_data.r0_value     = r0_next;
        push_data.flags_nzcv   = flags_next;
        push_data.inst_class   = w_valid_reg ? CLS_LS : e_cls;
        push_data.branch_taken = !w_valid_reg && e_taken;
        push_data.halted       = (pc_next == 32'd0);
        push_data.dp_count     = cnt_dp_next;
        push_data.branch_total = cnt_br_next;
        push_data.memory_total = cnt_mem_next;
        push_data.taken_total  = cnt_tk_next;
    end

    ase_outq u_outq (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .count     (oq_count),
        .rsp       (rsp)
    );

endmodule

`default_nettype wire

// ----- rtl/ase_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Simple dual-port RAM, one write and one registered read per cycle.
// A read of the address being written returns the old contents.
module ase_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ----- rtl/ase_regfile.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Register file: one RAM copy per read port, all written together.
// Entries never written read as zero; the write of the read cycle is forwarded.
module ase_regfile import ase_pkg::*; (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic [RD_PORTS-1:0][REG_AW-1:0]    raddr,
    input  wire rf_wr_t                             wr,
    output logic      [RD_PORTS-1:0][31:0]          rdata
);

    logic [NUM_REGS-1:0]              valid_reg;
    logic [NUM_REGS-1:0]              valid_next;
    logic                             fwd_en_reg;
    logic [REG_AW-1:0]                fwd_addr_reg;
    logic [31:0]                      fwd_data_reg;
    logic [RD_PORTS-1:0][REG_AW-1:0]  raddr_reg;
    logic [RD_PORTS-1:0][31:0]        ram_q;

    always_comb
    begin
        valid_next = valid_reg;
        if (wr.en)
        begin
            valid_next[wr.addr] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= '0;
            fwd_en_reg <= 1'b0;
        end
        else
        begin
            valid_reg  <= valid_next;
            fwd_en_reg <= wr.en;
        end
    end

    always_ff @(posedge clk)
    begin
        fwd_addr_reg <= wr.addr;
        fwd_data_reg <= wr.data;
        raddr_reg    <= raddr;
    end

    for (genvar p = 0; p < RD_PORTS; p++)
    begin : g_port
        ase_ram #(
            .WIDTH (32),
            .DEPTH (NUM_REGS)
        ) u_copy (
            .clk   (clk),
            .we    (wr.en),
            .waddr (wr.addr),
            .wdata (wr.data),
            .raddr (raddr[p]),
            .rdata (ram_q[p])
        );

        assign rdata[p] = (fwd_en_reg && (fwd_addr_reg == raddr_reg[p])) ? fwd_data_reg :
                          (valid_reg[raddr_reg[p]] ? ram_q[p] : 32'd0);
    end

endmodule

`default_nettype wire

// ----- rtl/ase_dmem.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Byte data memory as four byte-lane banks, so that any word, aligned or not,
// touches each bank once. Addresses wrap at the memory size. After reset a
// clearing pass writes zero to every row while busy is high.
module ase_dmem import ase_pkg::*; #(
    parameter int DMEM_BYTES = DMEM_BYTES_DEF
) (
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire dm_cmd_t cmd,
    output logic [31:0]  rdata,
    output logic         busy
);

    localparam int AW     = $clog2(DMEM_BYTES);
    localparam int ROWS   = DMEM_BYTES / 4;
    localparam int ROW_AW = AW - 2;

    logic [AW-1:0]     addr;
    logic              clearing_reg;
    logic              clearing_next;
    logic [ROW_AW-1:0] clr_row_reg;
    logic [ROW_AW-1:0] clr_row_next;
    logic [1:0]        lane_reg;
    logic              byte_reg;
    logic [3:0][7:0]   bank_q;
    logic [31:0]       word;

    assign addr = cmd.addr[AW-1:0];
    assign busy = clearing_reg;

    always_comb
    begin
        clearing_next = clearing_reg;
        clr_row_next  = clr_row_reg;
        if (clearing_reg)
        begin
            clr_row_next = clr_row_reg + 1'b1;
            if (clr_row_reg == ROW_AW'(ROWS - 1))
            begin
                clearing_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clearing_reg <= 1'b1;
            clr_row_reg  <= '0;
        end
        else
        begin
            clearing_reg <= clearing_next;
            clr_row_reg  <= clr_row_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.en)
        begin
            lane_reg <= addr[1:0];
            byte_reg <= cmd.byte_op;
        end
    end

    for (genvar b = 0; b < 4; b++)
    begin : g_bank
        logic [1:0]        idx;
        logic [AW-1:0]     baddr;
        logic [ROW_AW-1:0] row;
        logic              we;
        logic [7:0]        wd;

        // Byte of the word that lands in this bank, and its wrapped address.
        assign idx   = 2'(b) - addr[1:0];
        assign baddr = addr + AW'(idx);
        assign row   = clearing_reg ? clr_row_reg : baddr[AW-1:2];
        assign we    = clearing_reg ||
                       (cmd.en && cmd.wr && (!cmd.byte_op || (addr[1:0] == 2'(b))));
        assign wd    = clearing_reg ? 8'd0 : 8'(cmd.wdata >> {idx, 3'b000});

        ase_ram #(
            .WIDTH (8),
            .DEPTH (ROWS)
        ) u_bank (
            .clk   (clk),
            .we    (we),
            .waddr (row),
            .wdata (wd),
            .raddr (row),
            .rdata (bank_q[b])
        );
    end

    assign word[7:0]   = bank_q[lane_reg];
    assign word[15:8]  = bank_q[lane_reg + 2'd1];
    assign word[23:16] = bank_q[lane_reg + 2'd2];
    assign word[31:24] = bank_q[lane_reg + 2'd3];

    assign rdata = byte_reg ? {24'd0, word[7:0]} : word;

endmodule

`default_nettype wire

// ----- rtl/ase_outq.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Result queue between the execute logic and the response channel.
module ase_outq import ase_pkg::*; (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 push,
    input  wire rsp_t                 push_data,
    output logic [OQ_CNT_W-1:0]       count,
    ase_rsp_if.source                 rsp
);

    rsp_t                entries_reg [OUT_DEPTH];
    logic [OQ_PTR_W-1:0] head_reg;
    logic [OQ_PTR_W-1:0] head_next;
    logic [OQ_PTR_W-1:0] tail_reg;
    logic [OQ_PTR_W-1:0] tail_next;
    logic [OQ_CNT_W-1:0] count_reg;
    logic [OQ_CNT_W-1:0] count_next;
    logic                pop;
    rsp_t                head_data;

    assign pop   = (count_reg != '0) && rsp.ready;
    assign count = count_reg;

    always_comb
    begin
        head_next  = head_reg;
        tail_next  = tail_reg;
        count_next = count_reg;
        if (pop)
        begin
            head_next = head_reg + 1'b1;
        end
        if (push)
        begin
            tail_next = tail_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries_reg[tail_reg] <= push_data;
        end
    end

    assign head_data = entries_reg[head_reg];

    assign rsp.valid        = (count_reg != '0);
    assign rsp.next_pc      = head_data.next_pc;
    assign rsp.r0_value     = head_data.r0_value;
    assign rsp.flags_nzcv   = head_data.flags_nzcv;
    assign rsp.inst_class   = head_data.inst_class;
    assign rsp.branch_taken = head_data.branch_taken;
    assign rsp.halted       = head_data.halted;
    assign rsp.dp_count     = head_data.dp_count;
    assign rsp.branch_total = head_data.branch_total;
    assign rsp.memory_total = head_data.memory_total;
    assign rsp.taken_total  = head_data.taken_total;

endmodule

`default_nettype wire
